/* sv/fmc_pkg.sv */
package fmc_pkg;

  localparam int unsigned TypeW    = 6;
  localparam int unsigned CatW     = 4;
  localparam int unsigned MaxType  = 39;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 16;

  typedef logic [MaxType:1] hit_t;

  localparam logic [TypeW-1:0] TypeUnknown  = 6'd0;
  localparam logic [TypeW-1:0] TypeForm     = 6'd1;
  localparam logic [TypeW-1:0] TypeLwob     = 6'd2;
  localparam logic [TypeW-1:0] TypeLwlo     = 6'd3;
  localparam logic [TypeW-1:0] TypeLwsc     = 6'd4;
  localparam logic [TypeW-1:0] TypeLwo2     = 6'd5;
  localparam logic [TypeW-1:0] TypeTddd     = 6'd6;
  localparam logic [TypeW-1:0] TypeIlbm     = 6'd7;
  localparam logic [TypeW-1:0] Type8svx     = 6'd8;
  localparam logic [TypeW-1:0] TypeAnim     = 6'd9;
  localparam logic [TypeW-1:0] TypeXpkf     = 6'd10;
  localparam logic [TypeW-1:0] TypeSqsh     = 6'd11;
  localparam logic [TypeW-1:0] TypeNuke     = 6'd12;
  localparam logic [TypeW-1:0] TypePp20     = 6'd13;
  localparam logic [TypeW-1:0] TypeLzx      = 6'd14;
  localparam logic [TypeW-1:0] TypeRar      = 6'd15;
  localparam logic [TypeW-1:0] TypeMed      = 6'd16;
  localparam logic [TypeW-1:0] TypeDigi     = 6'd17;
  localparam logic [TypeW-1:0] TypeDbm0     = 6'd18;
  localparam logic [TypeW-1:0] TypeSymm     = 6'd19;
  localparam logic [TypeW-1:0] TypeRiff     = 6'd20;
  localparam logic [TypeW-1:0] TypeWave     = 6'd21;
  localparam logic [TypeW-1:0] TypeAvi      = 6'd22;
  localparam logic [TypeW-1:0] TypeDosDisk  = 6'd23;
  localparam logic [TypeW-1:0] TypeBzip2    = 6'd24;
  localparam logic [TypeW-1:0] TypeGzip     = 6'd25;
  localparam logic [TypeW-1:0] TypeCompress = 6'd26;
  localparam logic [TypeW-1:0] TypeMz       = 6'd27;
  localparam logic [TypeW-1:0] TypeJpeg     = 6'd28;
  localparam logic [TypeW-1:0] Type7z       = 6'd29;
  localparam logic [TypeW-1:0] TypeXz       = 6'd30;
  localparam logic [TypeW-1:0] TypeDms      = 6'd31;
  localparam logic [TypeW-1:0] TypeZip      = 6'd32;
  localparam logic [TypeW-1:0] TypePng      = 6'd33;
  localparam logic [TypeW-1:0] TypeGif      = 6'd34;
  localparam logic [TypeW-1:0] TypeTiff     = 6'd35;
  localparam logic [TypeW-1:0] TypeElf      = 6'd36;
  localparam logic [TypeW-1:0] TypeHunkExe  = 6'd37;
  localparam logic [TypeW-1:0] TypeHunkLib  = 6'd38;
  localparam logic [TypeW-1:0] TypeLha      = 6'd39;

  localparam logic [CatW-1:0] CatUnknown = 4'd0;
  localparam logic [CatW-1:0] CatArchive = 4'd1;
  localparam logic [CatW-1:0] CatPacker  = 4'd2;
  localparam logic [CatW-1:0] CatModule  = 4'd3;
  localparam logic [CatW-1:0] CatVoice   = 4'd4;
  localparam logic [CatW-1:0] CatVideo   = 4'd5;
  localparam logic [CatW-1:0] Cat3d      = 4'd6;
  localparam logic [CatW-1:0] CatPicture = 4'd7;
  localparam logic [CatW-1:0] CatDisk    = 4'd8;
  localparam logic [CatW-1:0] CatProgram = 4'd9;

  localparam logic [31:0] TagForm = "FORM";
  localparam logic [31:0] TagLwob = "LWOB";
  localparam logic [31:0] TagLwlo = "LWLO";
  localparam logic [31:0] TagLwsc = "LWSC";
  localparam logic [31:0] TagLwo2 = "LWO2";
  localparam logic [31:0] TagTddd = "TDDD";
  localparam logic [31:0] TagIlbm = "ILBM";
  localparam logic [31:0] Tag8svx = "8SVX";
  localparam logic [31:0] TagAnim = "ANIM";
  localparam logic [31:0] TagXpkf = "XPKF";
  localparam logic [31:0] TagSqsh = "SQSH";
  localparam logic [31:0] TagNuke = "NUKE";
  localparam logic [31:0] TagPp20 = "PP20";
  localparam logic [23:0] TagLzx  = "LZX";
  localparam logic [23:0] TagRar  = "Rar";
  localparam logic [23:0] TagMmd  = "MMD";
  localparam logic [23:0] TagMed  = "MED";
  localparam logic [31:0] TagDigi = "DIGI";
  localparam logic [31:0] TagDbm0 = "DBM0";
  localparam logic [31:0] TagSymm = "SymM";
  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWave = "WAVE";
  localparam logic [31:0] TagAvi  = "AVI ";
  localparam logic [23:0] TagDos  = "DOS";

  localparam logic [31:0] MagicDms     = 32'h444D_5321;
  localparam logic [31:0] MagicZip     = 32'h504B_0304;
  localparam logic [31:0] MagicPng     = 32'h8950_4E47;
  localparam logic [31:0] MagicGif     = 32'h4749_4638;
  localparam logic [31:0] MagicTiffBe  = 32'h4D4D_002A;
  localparam logic [31:0] MagicTiffLe  = 32'h4949_2A00;
  localparam logic [31:0] MagicElf     = 32'h7F45_4C46;
  localparam logic [31:0] MagicHunkExe = 32'h0000_03F3;
  localparam logic [31:0] MagicHunkLib = 32'h0000_03E7;

  function automatic logic [CatW-1:0] category_of(input logic [TypeW-1:0] type_code);
    logic [CatW-1:0] cat;
    unique case (type_code)
      TypeLwob, TypeLwlo, TypeLwsc, TypeLwo2, TypeTddd: cat = Cat3d;
      TypeIlbm, TypeJpeg, TypePng, TypeGif, TypeTiff: cat = CatPicture;
      Type8svx, TypeWave: cat = CatVoice;
      TypeAnim, TypeAvi: cat = CatVideo;
      TypeXpkf, TypeSqsh, TypeNuke, TypePp20, TypeBzip2, TypeGzip, TypeCompress,
      Type7z, TypeXz: cat = CatPacker;
      TypeLzx, TypeRar, TypeZip, TypeLha: cat = CatArchive;
      TypeMed, TypeDigi, TypeDbm0, TypeSymm: cat = CatModule;
      TypeDosDisk, TypeDms: cat = CatDisk;
      TypeMz, TypeElf, TypeHunkExe, TypeHunkLib: cat = CatProgram;
      default: cat = CatUnknown;
    endcase
    return cat;
  endfunction

endpackage

/* sv/file_magic_classifier_core.sv */
// Channel  Dir  Fields (tdata / tuser)
// s_axis   in   tdata: head_bytes_low[63:0], head_bytes_high[95:64]; tuser: long_enough
// m_axis   out  tdata: type_code[5:0], category_code[9:6], zero[15:10]
//
// Three register stages: signature compare, priority encode, category lookup.
// One item per cycle sustained while m_axis_tready_i is high; an accepted item
// is registered in stages s1, s2 and s3 in turn before m_axis_tvalid_o rises.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage advances when empty or when the next one moves, so a stalled
// output holds its item and bubbles collapse behind it.
module file_magic_classifier_core
  import fmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // head_bytes_low, head_bytes_high
  input  logic                s_axis_tuser_i,   // long_enough
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // type_code, category_code, zero pad
);

  hit_t             hit;
  hit_t             s1_hit_q;
  logic             s1_valid_q, s2_valid_q, s3_valid_q;
  logic [TypeW-1:0] s2_type_d, s2_type_q, s3_type_q;
  logic [CatW-1:0]  s3_cat_q;
  logic             adv1, adv2, adv3;

  fmc_match u_match (
    .head_lo_i(s_axis_tdata_i[63:0]),
    .head_hi_i(s_axis_tdata_i[95:64]),
    .hit_o    (hit)
  );

  assign adv3 = !s3_valid_q || m_axis_tready_i;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;

  assign s_axis_tready_o = adv1;
  assign m_axis_tvalid_o = s3_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - TypeW - CatW){1'b0}}, s3_cat_q, s3_type_q};

  always_comb begin
    s2_type_d = TypeUnknown;
    for (int i = MaxType; i >= 1; i--) begin
      if (s1_hit_q[i]) begin
        s2_type_d = TypeW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= s_axis_tvalid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid_i) begin
      s1_hit_q <= s_axis_tuser_i ? hit : '0;
    end
    if (adv2 && s1_valid_q) begin
      s2_type_q <= s2_type_d;
    end
    if (adv3 && s2_valid_q) begin
      s3_type_q <= s2_type_q;
      s3_cat_q  <= category_of(s2_type_q);
    end
  end

`ifndef SYNTHESIS
  a_unknown_cat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_type_q == TypeUnknown) |-> s3_cat_q == CatUnknown)
    else $error("unknown type with nonzero category");

  a_type_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_type_q <= TypeW'(MaxType))
    else $error("type code out of range");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv2) |=> (s1_valid_q && $stable(s1_hit_q)))
    else $error("stage one item lost on stall");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && !m_axis_tready_i))
    else $error("input stalled with room in pipeline");
`endif

endmodule

/* sv/fmc_match.sv */
module fmc_match
  import fmc_pkg::*;
(
  input  logic [63:0] head_lo_i,
  input  logic [31:0] head_hi_i,
  output hit_t        hit_o
);

  logic [31:0] w0;
  logic [23:0] t3;
  logic [7:0]  b0, b1, b2, b3, b4, b6;
  logic        form, xpkf, riff;
  logic        form_sub, xpkf_sub, riff_sub;

  assign w0 = head_lo_i[63:32];
  assign t3 = head_lo_i[63:40];
  assign b0 = head_lo_i[63:56];
  assign b1 = head_lo_i[55:48];
  assign b2 = head_lo_i[47:40];
  assign b3 = head_lo_i[39:32];
  assign b4 = head_lo_i[31:24];
  assign b6 = head_lo_i[15:8];

  assign form = (w0 == TagForm);
  assign xpkf = (w0 == TagXpkf);
  assign riff = (w0 == TagRiff);

  always_comb begin
    hit_o = '0;
    hit_o[TypeLwob] = form && (head_hi_i == TagLwob);
    hit_o[TypeLwlo] = form && (head_hi_i == TagLwlo);
    hit_o[TypeLwsc] = form && (head_hi_i == TagLwsc);
    hit_o[TypeLwo2] = form && (head_hi_i == TagLwo2);
    hit_o[TypeTddd] = form && (head_hi_i == TagTddd);
    hit_o[TypeIlbm] = form && (head_hi_i == TagIlbm);
    hit_o[Type8svx] = form && (head_hi_i == Tag8svx);
    hit_o[TypeAnim] = form && (head_hi_i == TagAnim);
    form_sub = |hit_o[TypeAnim:TypeLwob];
    hit_o[TypeForm] = form && !form_sub;

    hit_o[TypeSqsh] = xpkf && (head_hi_i == TagSqsh);
    hit_o[TypeNuke] = xpkf && (head_hi_i == TagNuke);
    xpkf_sub = hit_o[TypeSqsh] || hit_o[TypeNuke];
    hit_o[TypeXpkf] = xpkf && !xpkf_sub;

    hit_o[TypePp20] = (w0 == TagPp20);
    hit_o[TypeLzx]  = (t3 == TagLzx);
    hit_o[TypeRar]  = (t3 == TagRar);
    hit_o[TypeMed]  = (t3 == TagMmd) || (t3 == TagMed);
    hit_o[TypeDigi] = (w0 == TagDigi);
    hit_o[TypeDbm0] = (w0 == TagDbm0);
    hit_o[TypeSymm] = (w0 == TagSymm);

    hit_o[TypeWave] = riff && (head_hi_i == TagWave);
    hit_o[TypeAvi]  = riff && (head_hi_i == TagAvi);
    riff_sub = hit_o[TypeWave] || hit_o[TypeAvi];
    hit_o[TypeRiff] = riff && !riff_sub;

    hit_o[TypeDosDisk]  = (t3 == TagDos);
    hit_o[TypeBzip2]    = (b0 == 8'h42) && (b1 == 8'h5A);
    hit_o[TypeGzip]     = (b0 == 8'h1F) && (b1 == 8'h8B) && (b2 == 8'h08);
    hit_o[TypeCompress] = (b0 == 8'h1F) && (b1 == 8'h9D);
    hit_o[TypeMz]       = (b0 == 8'h4D) && (b1 == 8'h5A);
    hit_o[TypeJpeg]     = (b0 == 8'hFF) && (b1 == 8'hD8) && (b2 == 8'hFF);
    hit_o[Type7z]       = (head_lo_i[63:16] == 48'h377A_BCAF_271C);
    hit_o[TypeXz]       = (head_lo_i[63:16] == 48'hFD37_7A58_5A00);

    hit_o[TypeDms]     = (w0 == MagicDms);
    hit_o[TypeZip]     = (w0 == MagicZip);
    hit_o[TypePng]     = (w0 == MagicPng);
    hit_o[TypeGif]     = (w0 == MagicGif);
    hit_o[TypeTiff]    = (w0 == MagicTiffBe) || (w0 == MagicTiffLe);
    hit_o[TypeElf]     = (w0 == MagicElf);
    hit_o[TypeHunkExe] = (w0 == MagicHunkExe);
    hit_o[TypeHunkLib] = (w0 == MagicHunkLib);

    hit_o[TypeLha] = (b6 == "-") && (b2 == "-") && (b3 == "l") &&
                     ((b4 == "h") || (b4 == "z"));
  end

endmodule
